// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the weight update unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked property, checked only while out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Clocked property, checked during reset as well.
`define ASSERT_CLK_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK_ALL(lbl, clk, prop, msg)
`endif

`endif

// ----- src/sgdu_pkg.sv -----
// Types, constants and fixed-point helpers of the SGD weight update unit.
`default_nettype none

package sgdu_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = 32;
    localparam int EFF_W       = (VALUE_WIDTH > DATA_W) ? DATA_W :
                                 ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
    localparam int COEF_W      = 17;
    localparam int FRAC_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int WIDE_W      = 64;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

    localparam logic signed [WIDE_W-1:0] VMAX =
        (WIDE_W'(64'sd1) <<< (EFF_W - 1)) - WIDE_W'(64'sd1);
    localparam logic signed [WIDE_W-1:0] VMIN = -VMAX - WIDE_W'(64'sd1);
    localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(64'sd1) <<< (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE   = CFG_IDX_W'(0),
        REG_L1_DECAY        = CFG_IDX_W'(1),
        REG_L2_DECAY        = CFG_IDX_W'(2),
        REG_MOMENTUM_FACTOR = CFG_IDX_W'(3)
    } cfg_addr_t;

    typedef struct packed {
        logic [COEF_W-1:0] learning_rate;
        logic [COEF_W-1:0] l1_decay;
        logic [COEF_W-1:0] l2_decay;
        logic [COEF_W-1:0] momentum_factor;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] gradient;
        logic signed [DATA_W-1:0] momentum;
        logic        [DATA_W-1:0] step_scale;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_weight;
        logic signed [DATA_W-1:0] new_gradient;
        logic signed [DATA_W-1:0] new_momentum;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // Reads a port value in EFF_W bits with sign extension.
    function automatic logic signed [DATA_W-1:0] sext_in(input logic [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] t;
        t = $signed(x << (DATA_W - EFF_W));
        return t >>> (DATA_W - EFF_W);
    endfunction

    // Drops the 16 fraction bits, rounding to nearest with ties away from zero.
    function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [WIDE_W-1:0] p);
        logic signed [WIDE_W-1:0] a;
        a = ((p[WIDE_W-1] ? -p : p) + RND_HALF) >>> FRAC_W;
        return p[WIDE_W-1] ? -a : a;
    endfunction

    // Clips to the signed EFF_W-bit range and reports whether it clipped.
    function automatic sat_t sat(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        if (v > VMAX) begin
            r.hit = 1'b1;
            r.val = VMAX[DATA_W-1:0];
        end else if (v < VMIN) begin
            r.hit = 1'b1;
            r.val = VMIN[DATA_W-1:0];
        end else begin
            r.hit = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/sgdu_pipe.sv -----
// Nine-stage arithmetic pipeline of the SGD weight update unit.
`default_nettype none

module sgdu_pipe
    import sgdu_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    adv,
    input  wire logic    in_valid,
    input  wire item_t   in_item,
    input  wire cfg_t    cfg,
    output logic         out_valid,
    output result_t      out_res
);

    localparam int NSTAGE = 9;
    localparam int NARROW_W = COEF_W + DATA_W + 1;

    logic [NSTAGE-1:0] vld_reg;

    // Stage 1: operands and the L2 product.
    logic signed [DATA_W-1:0]   s1_w_reg, s1_g_reg, s1_mom_reg;
    logic        [DATA_W-1:0]   s1_scale_reg;
    logic signed [NARROW_W-1:0] s1_p2_reg;
    // Stage 2: gradient after L2 decay.
    logic signed [DATA_W-1:0]   s2_w_reg, s2_g_reg, s2_mom_reg;
    logic        [DATA_W-1:0]   s2_scale_reg;
    logic                       s2_flag_reg;
    // Stage 3: gradient after L1 decay.
    logic signed [DATA_W-1:0]   s3_w_reg, s3_g_reg, s3_mom_reg;
    logic        [DATA_W-1:0]   s3_scale_reg;
    logic                       s3_flag_reg;
    // Stage 4: gradient or momentum blend products.
    logic signed [DATA_W-1:0]   s4_w_reg, s4_g_reg, s4_mom_reg;
    logic        [DATA_W-1:0]   s4_scale_reg;
    logic signed [WIDE_W-1:0]   s4_prod_reg;
    logic signed [NARROW_W-1:0] s4_pa_reg, s4_pb_reg;
    logic                       s4_flag_reg;
    // Stage 5: scaled gradient (no inertia) or blended momentum.
    logic signed [DATA_W-1:0]   s5_w_reg, s5_g_reg, s5_mom_reg, s5_x_reg;
    logic        [DATA_W-1:0]   s5_scale_reg;
    logic                       s5_flag_reg;
    // Stage 6: momentum times step scale.
    logic signed [DATA_W-1:0]   s6_w_reg, s6_g_reg, s6_mom_reg, s6_x_reg;
    logic signed [WIDE_W-1:0]   s6_prod_reg;
    logic                       s6_flag_reg;
    // Stage 7: final gradient, momentum and update term.
    logic signed [DATA_W-1:0]   s7_w_reg, s7_ng_reg, s7_nm_reg, s7_upd_reg;
    logic                       s7_flag_reg;
    // Stage 8: learning rate product.
    logic signed [DATA_W-1:0]   s8_w_reg, s8_ng_reg, s8_nm_reg;
    logic signed [NARROW_W-1:0] s8_pu_reg;
    logic                       s8_flag_reg;
    // Stage 9: output register.
    result_t                    s9_res_reg;

    logic                       kz;
    logic signed [DATA_W-1:0]   in_w, in_g, in_mom;
    logic signed [NARROW_W-1:0] p2_next, pa_next, pb_next, pu_next;
    logic signed [WIDE_W-1:0]   prod4_next, prod6_next, sum3;
    sat_t                       sat2, sat3, sat5, sat7, sat9;
    logic                       l2_on, l1_on;
    logic        [COEF_W-1:0]   k_rest;

    assign kz     = (cfg.momentum_factor == '0);
    assign l2_on  = (cfg.l2_decay != '0);
    assign l1_on  = (cfg.l1_decay != '0) && (s2_w_reg != '0);
    assign k_rest = COEF_ONE - cfg.momentum_factor;

    always_comb begin
        in_w    = sext_in(in_item.weight);
        in_g    = sext_in(in_item.gradient);
        in_mom  = sext_in(in_item.momentum);
        p2_next = $signed({1'b0, cfg.l2_decay}) * in_w;

        sat2 = sat(WIDE_W'(s1_g_reg) + rnd16(WIDE_W'(s1_p2_reg)));

        if (s2_w_reg[DATA_W-1]) begin
            sum3 = WIDE_W'(s2_g_reg) - $signed(WIDE_W'(cfg.l1_decay));
        end else begin
            sum3 = WIDE_W'(s2_g_reg) + $signed(WIDE_W'(cfg.l1_decay));
        end
        sat3 = sat(sum3);

        prod4_next = s3_g_reg * $signed({1'b0, s3_scale_reg});
        pa_next    = $signed({1'b0, k_rest}) * s3_g_reg;
        pb_next    = $signed({1'b0, cfg.momentum_factor}) * s3_mom_reg;

        if (kz) begin
            sat5 = sat(rnd16(s4_prod_reg));
        end else begin
            sat5 = sat(rnd16(WIDE_W'(s4_pa_reg) + WIDE_W'(s4_pb_reg)));
        end

        prod6_next = s5_x_reg * $signed({1'b0, s5_scale_reg});
        sat7       = sat(rnd16(s6_prod_reg));
        pu_next    = $signed({1'b0, cfg.learning_rate}) * s7_upd_reg;
        sat9       = sat(WIDE_W'(s8_w_reg) - rnd16(WIDE_W'(s8_pu_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_w_reg     <= in_w;
            s1_g_reg     <= in_g;
            s1_mom_reg   <= in_mom;
            s1_scale_reg <= in_item.step_scale;
            s1_p2_reg    <= p2_next;

            s2_w_reg     <= s1_w_reg;
            s2_g_reg     <= l2_on ? sat2.val : s1_g_reg;
            s2_mom_reg   <= s1_mom_reg;
            s2_scale_reg <= s1_scale_reg;
            s2_flag_reg  <= l2_on && sat2.hit;

            s3_w_reg     <= s2_w_reg;
            s3_g_reg     <= l1_on ? sat3.val : s2_g_reg;
            s3_mom_reg   <= s2_mom_reg;
            s3_scale_reg <= s2_scale_reg;
            s3_flag_reg  <= s2_flag_reg || (l1_on && sat3.hit);

            s4_w_reg     <= s3_w_reg;
            s4_g_reg     <= s3_g_reg;
            s4_mom_reg   <= s3_mom_reg;
            s4_scale_reg <= s3_scale_reg;
            s4_prod_reg  <= prod4_next;
            s4_pa_reg    <= pa_next;
            s4_pb_reg    <= pb_next;
            s4_flag_reg  <= s3_flag_reg;

            s5_w_reg     <= s4_w_reg;
            s5_g_reg     <= s4_g_reg;
            s5_mom_reg   <= s4_mom_reg;
            s5_scale_reg <= s4_scale_reg;
            s5_x_reg     <= sat5.val;
            s5_flag_reg  <= s4_flag_reg || sat5.hit;

            s6_w_reg     <= s5_w_reg;
            s6_g_reg     <= s5_g_reg;
            s6_mom_reg   <= s5_mom_reg;
            s6_x_reg     <= s5_x_reg;
            s6_prod_reg  <= prod6_next;
            s6_flag_reg  <= s5_flag_reg;

            // Without inertia the scaled gradient is the update; otherwise the
            // scaled momentum is.
            s7_w_reg     <= s6_w_reg;
            s7_ng_reg    <= kz ? s6_x_reg : s6_g_reg;
            s7_nm_reg    <= kz ? s6_mom_reg : sat7.val;
            s7_upd_reg   <= kz ? s6_x_reg : sat7.val;
            s7_flag_reg  <= s6_flag_reg || (!kz && sat7.hit);

            s8_w_reg     <= s7_w_reg;
            s8_ng_reg    <= s7_ng_reg;
            s8_nm_reg    <= s7_nm_reg;
            s8_pu_reg    <= pu_next;
            s8_flag_reg  <= s7_flag_reg;

            s9_res_reg.new_weight   <= sat9.val;
            s9_res_reg.new_gradient <= s8_ng_reg;
            s9_res_reg.new_momentum <= s8_nm_reg;
            s9_res_reg.saturated    <= s8_flag_reg || sat9.hit;
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign out_res   = s9_res_reg;

endmodule

`default_nettype wire

// ----- src/sgd_weight_update_unit.sv -----
// SGD weight update unit: L2/L1 decay, optional momentum, saturating Q16.16 update.
//
// One weight element enters per beat and one result leaves per beat; the
// sustained rate is one item per clock cycle while m_tready is high. Each beat
// runs through the nine-stage multiply and round/saturate pipeline (the chain
// L2 product, decay adds, blend or scale product, momentum scale product,
// learning rate product, final subtract). The whole pipeline stalls together
// while the result beat is held; a one-entry input skid buffer keeps s_tready
// a registered signal. Coefficients above 1.0 are used as 1.0. The user must
// write registers only while no item is in flight; the unit does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module sgd_weight_update_unit
    import sgdu_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input beats.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // weight [31:0], gradient [63:32], momentum [95:64], step_scale [127:96]
    input  wire logic [4*DATA_W-1:0]    s_tdata,
    // Result beats.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // new_weight [31:0], new_gradient [63:32], new_momentum [95:64]
    output logic [3*DATA_W-1:0]         m_tdata,
    // saturated [0]
    output logic                        m_tuser,
    // Register writes.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COEF_W-1:0]      cfg_data
);

    cfg_t        cfg_reg;
    logic        skid_valid_reg;
    item_t       skid_item_reg;
    item_t       s_item;
    item_t       pipe_item;
    logic        pipe_in_valid;
    logic        s_accept;
    logic        adv;
    logic [COEF_W-1:0] cfg_val;
    result_t     res;

    assign cfg_ready = 1'b1;
    assign cfg_val   = (cfg_data > COEF_ONE) ? COEF_ONE : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr_t'(cfg_index))
                REG_LEARNING_RATE:   cfg_reg.learning_rate   <= cfg_val;
                REG_L1_DECAY:        cfg_reg.l1_decay        <= cfg_val;
                REG_L2_DECAY:        cfg_reg.l2_decay        <= cfg_val;
                REG_MOMENTUM_FACTOR: cfg_reg.momentum_factor <= cfg_val;
                default: begin
                end
            endcase
        end
    end

    assign s_item.weight     = $signed(s_tdata[DATA_W-1:0]);
    assign s_item.gradient   = $signed(s_tdata[2*DATA_W-1:DATA_W]);
    assign s_item.momentum   = $signed(s_tdata[3*DATA_W-1:2*DATA_W]);
    assign s_item.step_scale = s_tdata[4*DATA_W-1:3*DATA_W];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    assign pipe_in_valid = skid_valid_reg || s_accept;
    assign pipe_item     = skid_valid_reg ? skid_item_reg : s_item;

    // A beat that arrives while the pipeline is stalled parks in the skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (adv) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept && !adv) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && s_accept && !adv) begin
            skid_item_reg <= s_item;
        end
    end

    sgdu_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pipe_in_valid),
        .in_item   (pipe_item),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {res.new_momentum, res.new_gradient, res.new_weight};
    assign m_tuser = res.saturated;

    `ASSERT_CLK(a_skid_fill_on_stall, aclk, aresetn, $rose(skid_valid_reg) |-> $past(!adv), "skid entry filled while the pipeline was advancing")
    `ASSERT_CLK_ALL(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid, "result after reset")
    `ASSERT_CLK(a_coef_clamped, aclk, aresetn, (cfg_reg.learning_rate <= COEF_ONE) && (cfg_reg.l1_decay <= COEF_ONE) && (cfg_reg.l2_decay <= COEF_ONE) && (cfg_reg.momentum_factor <= COEF_ONE), "coefficient register above one")

endmodule

`default_nettype wire
